// ===== hdl/lesc_pkg.sv =====
// shared types, command codes and bitmap search functions for the look elevator scheduler
// no dependencies
`timescale 1ns / 1ps

package lesc_pkg;

  localparam int unsigned FLOOR_W   = 6;
  localparam int unsigned MAP_W     = 64;
  localparam int unsigned CMD_W     = 2;

  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [MAP_W-1:0]   map_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_CANCEL = 2'd1,
    CMD_SERVE  = 2'd2
  } cmd_t;

  // lowest set bit, binary search in six halving steps; v assumed nonzero
  function automatic floor_t low_index(input map_t v);
    map_t   w;
    floor_t idx;
    w   = v;
    idx = '0;
    for (int b = FLOOR_W - 1; b >= 0; b--) begin
      if ((w & ((map_t'(1) << (1 << b)) - map_t'(1))) == '0) begin
        idx[b] = 1'b1;
        w      = w >> (1 << b);
      end
    end
    return idx;
  endfunction

  // highest set bit, same halving search from the top
  function automatic floor_t high_index(input map_t v);
    map_t   w;
    floor_t idx;
    w   = v;
    idx = '0;
    for (int b = FLOOR_W - 1; b >= 0; b--) begin
      if ((w >> (1 << b)) != '0) begin
        idx[b] = 1'b1;
        w      = w >> (1 << b);
      end
    end
    return idx;
  endfunction

endpackage

// ===== hdl/lesc_step.sv =====
// next-state logic for one command: add, cancel or serve one stop in look order
// depends on lesc_pkg
`timescale 1ns / 1ps

module lesc_step #(
  parameter int unsigned FLOORS = 64
) (
  input  lesc_pkg::cmd_t   cmd,
  input  lesc_pkg::floor_t floor,
  input  logic [FLOORS-1:0] pending,
  input  lesc_pkg::floor_t here,
  input  logic             heading_up,
  output logic [FLOORS-1:0] pending_next,
  output lesc_pkg::floor_t here_next,
  output logic             heading_up_next
);
  import lesc_pkg::*;

  map_t   pend;
  map_t   req_bit;
  map_t   cand_up;
  map_t   cand_dn;
  map_t   pend_out;
  floor_t target;

  assign pend    = map_t'(pending);
  // bits at or above FLOORS fall off when narrowed, so out-of-range floors do nothing
  assign req_bit = map_t'(1) << floor;
  assign cand_up = pend & ({MAP_W{1'b1}} << here);
  assign cand_dn = pend & ({MAP_W{1'b1}} >> (~here));

  always_comb begin
    pend_out        = pend;
    here_next       = here;
    heading_up_next = heading_up;
    target          = here;
    unique case (cmd)
      CMD_ADD:    pend_out = pend | req_bit;
      CMD_CANCEL: pend_out = pend & ~req_bit;
      CMD_SERVE: begin
        if (pend != '0) begin
          if (heading_up) begin
            if (cand_up != '0) begin
              target = low_index(cand_up);
            end else begin
              heading_up_next = 1'b0;
              target          = high_index(pend);
            end
          end else begin
            if (cand_dn != '0) begin
              target = high_index(cand_dn);
            end else begin
              heading_up_next = 1'b1;
              target          = low_index(pend);
            end
          end
          here_next = target;
          pend_out  = pend & ~(map_t'(1) << target);
        end
      end
      default: pend_out = pend;
    endcase
  end

  assign pending_next = pend_out[FLOORS-1:0];

endmodule

// ===== hdl/look_elevator_scheduler.sv =====
// top level of the look elevator scheduler: input register, state, result register
// depends on lesc_pkg and lesc_step
`timescale 1ns / 1ps
//
//  channel   dir  tdata                                   tuser
//  s_axis    in   [5:0] floor, [7:6] zero                  [1:0] cmd
//  m_axis    out  [5:0] location, [6] going_up,            none
//                 [7] any_pending
//
// one item per cycle unless m_axis stalls; a result is valid on m_axis once its input transfer
// has passed the input register, then the step logic that updates state and the result register
// rst clears the pending map, sets location 0 heading up and empties both stages
// a stall on m_axis holds the result and backs up into s_tready through both stages

module look_elevator_scheduler #(
  parameter int unsigned FLOORS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [5:0] floor, [7:6] zero
  input  logic [1:0] s_tuser,   // [1:0] cmd
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata    // [5:0] location, [6] going_up, [7] any_pending
);
  import lesc_pkg::*;

  logic              in_valid;
  cmd_t              in_cmd;
  floor_t            in_floor;
  logic              advance;

  logic [FLOORS-1:0] pending;
  floor_t            here;
  logic              heading_up;
  logic [FLOORS-1:0] pending_next;
  floor_t            here_next;
  logic              heading_up_next;

  logic              out_valid;
  floor_t            out_location;
  logic              out_going_up;
  logic              out_any;

  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd   <= cmd_t'(s_tuser);
      in_floor <= s_tdata[FLOOR_W-1:0];
    end
  end

  lesc_step #(
    .FLOORS(FLOORS)
  ) u_step (
    .cmd             (in_cmd),
    .floor           (in_floor),
    .pending         (pending),
    .here            (here),
    .heading_up      (heading_up),
    .pending_next    (pending_next),
    .here_next       (here_next),
    .heading_up_next (heading_up_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      here       <= '0;
      heading_up <= 1'b1;
    end else if (advance) begin
      pending    <= pending_next;
      here       <= here_next;
      heading_up <= heading_up_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_location <= here_next;
      out_going_up <= heading_up_next;
      out_any      <= |pending_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_any, out_going_up, out_location};

endmodule

// ===== test/look_elevator_scheduler_checker.sv =====
// checker for the look elevator scheduler: watches both stream channels, predicts each result
// and compares it field by field; depends on lesc_pkg
`timescale 1ns / 1ps

module look_elevator_scheduler_checker #(
  parameter int unsigned FLOORS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  output int unsigned fail_count,
  output int unsigned awaited,
  output int unsigned stops_checked
);
  import lesc_pkg::*;

  // same packing as m_tdata, lowest field last
  typedef struct packed {
    logic   any_pending;
    logic   going_up;
    floor_t location;
  } car_status_t;

  map_t        calls;
  floor_t      cab_floor;
  logic        cab_up;
  car_status_t status_q[$];

  // applies one command to the model car and returns the status it reports
  function automatic car_status_t step_car(input logic [1:0] op, input floor_t fl);
    car_status_t st;
    int          target;
    target = -1;
    case (op)
      CMD_ADD: begin
        if (fl < FLOORS) calls[fl] = 1'b1;
      end
      CMD_CANCEL: begin
        if (fl < FLOORS) calls[fl] = 1'b0;
      end
      CMD_SERVE: begin
        if (calls != '0) begin
          if (cab_up) begin
            for (int i = 0; i < MAP_W; i++)
              if (target < 0 && i >= cab_floor && calls[i]) target = i;
            if (target < 0) begin
              // nothing above: turn around and take the top call
              cab_up = 1'b0;
              for (int i = MAP_W - 1; i >= 0; i--)
                if (target < 0 && calls[i]) target = i;
            end
          end else begin
            for (int i = MAP_W - 1; i >= 0; i--)
              if (target < 0 && i <= cab_floor && calls[i]) target = i;
            if (target < 0) begin
              cab_up = 1'b1;
              for (int i = 0; i < MAP_W; i++)
                if (target < 0 && calls[i]) target = i;
            end
          end
          cab_floor     = floor_t'(target);
          calls[target] = 1'b0;
        end
      end
      default: ;
    endcase
    st.location    = cab_floor;
    st.going_up    = cab_up;
    st.any_pending = (calls != '0);
    return st;
  endfunction

  task automatic flag(input string what, input int unsigned want, input int unsigned got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch in %s of result %0d: expected %0d, got %0d",
               what, stops_checked, want, got);
  endtask

  always @(posedge clk) begin
    car_status_t got;
    car_status_t want;
    if (rst) begin
      calls         = '0;
      cab_floor     = '0;
      cab_up        = 1'b1;
      status_q.delete();
      fail_count    = 0;
      stops_checked = 0;
    end else begin
      // results come out only after their command passes the input register, so popping first is safe
      if (m_tvalid && m_tready) begin
        got = m_tdata;
        if (status_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result transfer %h with nothing expected", m_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.location != want.location)
            flag("location", 32'(want.location), 32'(got.location));
          if (got.going_up != want.going_up)
            flag("going_up", 32'(want.going_up), 32'(got.going_up));
          if (got.any_pending != want.any_pending)
            flag("any_pending", 32'(want.any_pending), 32'(got.any_pending));
          stops_checked++;
        end
      end
      if (s_tvalid && s_tready)
        status_q.push_back(step_car(s_tuser, s_tdata[5:0]));
    end
    awaited = status_q.size();
  end

endmodule

// ===== test/look_elevator_scheduler_tb.sv =====
// testbench top for the look elevator scheduler: clock, reset, command stimulus and verdict
// depends on lesc_pkg, look_elevator_scheduler and look_elevator_scheduler_checker
`timescale 1ns / 1ps

module look_elevator_scheduler_tb;
  import lesc_pkg::*;

  localparam int unsigned FLOORS      = 64;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam int unsigned PHASE_ITEMS = 250;
  localparam int unsigned SETTLE      = 10;
  localparam int unsigned QUIET_LIMIT = 2000;

  logic       clk      = 1'b0;
  logic       rst      = 1'b1;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = '0;
  logic [1:0] s_tuser  = '0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned stops_checked;
  int unsigned sent_items    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned quiet_cycles  = 0;
  floor_t      recent_floor  = '0;

  look_elevator_scheduler #(.FLOORS(FLOORS)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  look_elevator_scheduler_checker #(.FLOORS(FLOORS)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .fail_count    (fail_count),
    .awaited       (awaited),
    .stops_checked (stops_checked)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles, %0d results outstanding", quiet_cycles, awaited);
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge; returns at the edge where the transfer happens
  task automatic push_cmd(input logic [1:0] op, input floor_t fl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {2'b00, fl};
    do @(posedge clk); while (!s_tready);
    sent_items++;
  endtask

  // holds off the sender until every predicted result has been seen
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin
    int unsigned pick;
    int unsigned directed;
    logic [1:0]  op;
    floor_t      fl;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: empty serve, unused command, repeats, both turnarounds, extremes
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_UNUSED, 6'd63);
    push_cmd(CMD_ADD,    6'd63);
    push_cmd(CMD_ADD,    6'd63);
    push_cmd(CMD_ADD,    6'd0);
    push_cmd(CMD_CANCEL, 6'd5);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_SERVE,  6'd63);
    push_cmd(CMD_ADD,    6'd10);
    push_cmd(CMD_ADD,    6'd40);
    push_cmd(CMD_ADD,    6'd62);
    push_cmd(CMD_SERVE,  6'd21);
    push_cmd(CMD_SERVE,  6'd42);
    push_cmd(CMD_ADD,    6'd50);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_ADD,    6'd63);
    push_cmd(CMD_ADD,    6'd0);
    push_cmd(CMD_CANCEL, 6'd63);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_ADD,    6'd42);
    push_cmd(CMD_ADD,    6'd21);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_SERVE,  6'd0);
    push_cmd(CMD_SERVE,  6'd0);
    directed = sent_items;
    drain_results();

    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 29;
          recv_idle_pct = 55;
        end
        1: begin
          send_idle_pct = 55;
          recv_idle_pct = 29;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 45)      op = CMD_ADD;
        else if (pick < 60) op = CMD_CANCEL;
        else if (pick < 95) op = CMD_SERVE;
        else                op = CMD_UNUSED;
        // cancels often hit a floor that was just requested
        if (op == CMD_CANCEL && $urandom_range(1) == 1)
          fl = recent_floor;
        else if ($urandom_range(9) == 0)
          fl = $urandom_range(1) ? 6'd63 : 6'd0;
        else
          fl = floor_t'($urandom_range(63));
        if (op == CMD_ADD) recent_floor = fl;
        push_cmd(op, fl);
        if (n == PHASE_ITEMS / 2) drain_results();
      end
      drain_results();
    end

    repeat (SETTLE) @(negedge clk);
    $display("summary: %0d commands sent (%0d directed), %0d results compared",
             sent_items, directed, stops_checked);
    $display("summary: stalls sender/receiver 29/55, then 55/29, then none, drained mid-phase");
    if (fail_count == 0 && awaited == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d mismatches, %0d results never arrived", fail_count, awaited);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
